// File: src/sapr_pkg.sv
// ---------------------------------------------------------------------------
// sapr_pkg
// shared types and constants of the streaming-aware pc-reuse replacement core
// ---------------------------------------------------------------------------
package sapr_pkg;

    localparam int NUM_SETS_DEF         = 2048;
    localparam int NUM_WAYS_DEF         = 16;
    localparam int PC_TABLE_ENTRIES_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF      = 2;

    localparam int SET_IN_W   = 11;
    localparam int WAY_IN_W   = 4;
    localparam int PC_W       = 64;
    localparam int COUNT_W    = 32;
    localparam int REUSE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [REUSE_W-1:0] REUSE_MAX = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_NUM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_DEN    = 2'd2;

    localparam logic ACT_VICTIM = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // one classified request as it travels from front to back
    typedef struct packed {
        logic                action;
        logic [SET_IN_W-1:0] set_index;
        logic [WAY_IN_W-1:0] way_index;
        logic [PC_W-1:0]     pc;
        logic                hit;
    } req_t;

endpackage

// File: src/sapr_front.sv
// ---------------------------------------------------------------------------
// sapr_front
// accepts command beats and queues them for the back end
// ---------------------------------------------------------------------------
module sapr_front #(
    parameter int QUEUE_DEPTH = sapr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sapr_pkg::req_t                    req_in,
    output logic                              req_valid,
    output sapr_pkg::req_t                    req_out,
    input  logic                              req_pop
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    sapr_pkg::req_t    queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic              push;

    assign busy      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign push      = start && !busy;
    assign req_valid = (count_reg != '0);
    assign req_out   = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (req_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(req_pop);
        end
    end
endmodule

// File: src/sapr_back.sv
// ---------------------------------------------------------------------------
// sapr_back
// per-set state, reuse table and the victim / update sequencer
// ---------------------------------------------------------------------------
module sapr_back #(
    parameter int NUM_SETS         = sapr_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS         = sapr_pkg::NUM_WAYS_DEF,
    parameter int PC_TABLE_ENTRIES = sapr_pkg::PC_TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  sapr_pkg::req_t                   req,
    output logic                             req_pop,
    input  logic [15:0]                      access_window,
    input  logic [7:0]                       threshold_numerator,
    input  logic [7:0]                       threshold_denominator,
    output logic                             clearing,
    output logic                             result_valid,
    output logic [sapr_pkg::WAY_IN_W-1:0]    victim_way,
    output logic                             streaming
);
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int SLOT_W = $clog2(PC_TABLE_ENTRIES);
    localparam int RANK_ROW_W = NUM_WAYS * WAY_W;
    localparam int SLOT_ROW_W = NUM_WAYS * SLOT_W;
    localparam int CLR_W  = (SLOT_W > SET_W) ? SLOT_W : SET_W;
    localparam int CLR_N  = (PC_TABLE_ENTRIES > NUM_SETS) ? PC_TABLE_ENTRIES : NUM_SETS;
    localparam int CW     = sapr_pkg::COUNT_W;
    localparam int RW     = sapr_pkg::REUSE_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_PROD  = 3'd3;
    localparam logic [2:0] ST_JUDGE = 3'd4;
    localparam logic [2:0] ST_WALK  = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;

    // memories
    logic [RANK_ROW_W-1:0]          rank_mem  [NUM_SETS];
    logic [SLOT_ROW_W-1:0]          slot_mem  [NUM_SETS];
    logic [CW-1:0]                  acc_mem   [NUM_SETS];
    logic [CW-1:0]                  miss_mem  [NUM_SETS];
    logic [RW-1:0]                  reuse_mem [PC_TABLE_ENTRIES];

    logic [2:0]                     state_reg, state_next;
    logic [CLR_W:0]                 clr_reg;
    logic [WAY_W-1:0]               walk_reg;
    logic                           rd_phase_reg;
    logic                           res_reg;
    sapr_pkg::req_t                 cur_reg;
    logic [RANK_ROW_W-1:0]          rank_row_reg;
    logic [SLOT_ROW_W-1:0]          slot_row_reg;
    logic [CW-1:0]                  acc_reg, miss_reg;
    logic [RW-1:0]                  reuse_rd_reg;
    logic [WAY_W-1:0]               best_way_reg;
    logic [WAY_W-1:0]               best_rank_reg;
    logic [RW:0]                    best_reuse_reg;
    logic                           strm_reg;
    logic [CW+7:0]                  mis_prod_reg, acc_prod_reg;
    logic                           past_win_reg;
    logic [WAY_W-1:0]               res_way_reg;
    logic                           res_strm_reg;

    logic [SET_W-1:0]               set_idx;
    logic [SLOT_W-1:0]              upd_slot;
    logic [SLOT_W-1:0]              walk_slot;
    logic [SLOT_W-1:0]              reuse_rd_addr;
    logic                           way_ok;
    logic [WAY_W-1:0]               upd_way;
    logic [WAY_W-1:0]               old_rank;
    logic [WAY_W-1:0]               w_rank;
    logic [RW:0]                    w_reuse;
    logic                           w_take;
    logic                           last_way;
    logic [CW-1:0]                  acc_inc;
    logic [RANK_ROW_W-1:0]          rank_wr;
    logic [SLOT_ROW_W-1:0]          slot_wr;
    logic [RANK_ROW_W-1:0]          rank_init;

    assign set_idx   = SET_W'(cur_reg.set_index % NUM_SETS);
    assign upd_slot  = cur_reg.pc[SLOT_W-1:0];
    assign way_ok    = (32'(cur_reg.way_index) < 32'(NUM_WAYS));
    assign upd_way   = WAY_W'(cur_reg.way_index);
    assign old_rank  = rank_row_reg[upd_way*WAY_W +: WAY_W];
    assign walk_slot = slot_row_reg[walk_reg*SLOT_W +: SLOT_W];
    assign w_rank    = rank_row_reg[walk_reg*WAY_W +: WAY_W];
    assign w_reuse   = {1'b0, reuse_rd_reg};
    assign last_way  = (walk_reg == WAY_W'(NUM_WAYS-1));
    assign acc_inc   = (acc_reg == sapr_pkg::COUNT_MAX) ? acc_reg : acc_reg + 1'b1;
    assign clearing  = (state_reg == ST_CLEAR);
    assign req_pop   = (state_reg == ST_IDLE) && req_valid;
    // single reuse table read port: the update slot on entry, else the walked way
    assign reuse_rd_addr = (state_reg == ST_READ) ? upd_slot : walk_slot;

    assign w_take = strm_reg ? (w_rank >= best_rank_reg)
                  : ((w_reuse < best_reuse_reg) ||
                     ((w_reuse == best_reuse_reg) && (w_rank >= best_rank_reg)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (CLR_W+1)'(CLR_N-1)) state_next = ST_IDLE;
            ST_IDLE:  if (req_valid) state_next = ST_READ;
            ST_READ:  state_next = (cur_reg.action == sapr_pkg::ACT_VICTIM) ? ST_PROD
                                                                            : ST_WRITE;
            ST_PROD:  state_next = ST_JUDGE;
            ST_JUDGE: state_next = ST_WALK;
            ST_WALK:  if (rd_phase_reg && last_way) state_next = ST_IDLE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // new rank and slot rows for an update
    always_comb
    begin
        rank_wr = rank_row_reg;
        slot_wr = slot_row_reg;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (WAY_W'(w) == upd_way)
            begin
                rank_wr[w*WAY_W +: WAY_W] = '0;
                slot_wr[w*SLOT_W +: SLOT_W] = upd_slot;
            end
            else if (rank_row_reg[w*WAY_W +: WAY_W] < old_rank)
            begin
                rank_wr[w*WAY_W +: WAY_W] = rank_row_reg[w*WAY_W +: WAY_W] + 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            rank_init[w*WAY_W +: WAY_W] = WAY_W'(w);
        end
    end

    // memory side: reads on entry, writes on clear, on the access count of a victim and on update commit
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            if (clr_reg < (CLR_W+1)'(NUM_SETS))
            begin
                rank_mem[SET_W'(clr_reg)] <= rank_init;
                slot_mem[SET_W'(clr_reg)] <= '0;
                acc_mem[SET_W'(clr_reg)]  <= '0;
                miss_mem[SET_W'(clr_reg)] <= '0;
            end
            if (clr_reg < (CLR_W+1)'(PC_TABLE_ENTRIES))
            begin
                reuse_mem[SLOT_W'(clr_reg)] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_READ)
            begin
                rank_row_reg <= rank_mem[set_idx];
                slot_row_reg <= slot_mem[set_idx];
                acc_reg      <= acc_mem[set_idx];
                miss_reg     <= miss_mem[set_idx];
            end
            if (state_reg == ST_PROD)
            begin
                acc_mem[set_idx] <= acc_inc;
            end
            if ((state_reg == ST_WRITE) && way_ok)
            begin
                rank_mem[set_idx] <= rank_wr;
                slot_mem[set_idx] <= slot_wr;
                if (!cur_reg.hit && (miss_reg != sapr_pkg::COUNT_MAX))
                begin
                    miss_mem[set_idx] <= miss_reg + 1'b1;
                end
                if (cur_reg.hit)
                begin
                    reuse_mem[upd_slot] <= (reuse_rd_reg == sapr_pkg::REUSE_MAX)
                                           ? reuse_rd_reg : reuse_rd_reg + 1'b1;
                end
                else
                begin
                    reuse_mem[upd_slot] <= (reuse_rd_reg == '0) ? reuse_rd_reg
                                                                 : reuse_rd_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        reuse_rd_reg <= reuse_mem[reuse_rd_addr];
    end

    // products, streaming verdict and the way walk, a read phase and a compare phase a way
    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            cur_reg <= req;
        end
        if (state_reg == ST_PROD)
        begin
            mis_prod_reg <= {8'd0, miss_reg} * {32'd0, threshold_denominator};
            acc_prod_reg <= {8'd0, acc_inc} * {32'd0, threshold_numerator};
            past_win_reg <= acc_inc > {16'd0, access_window};
        end
        if (state_reg == ST_JUDGE)
        begin
            strm_reg       <= past_win_reg && (mis_prod_reg > acc_prod_reg);
            best_way_reg   <= '0;
            best_rank_reg  <= '0;
            best_reuse_reg <= {1'b0, sapr_pkg::REUSE_MAX} + 1'b1;
        end
        if ((state_reg == ST_WALK) && rd_phase_reg && w_take)
        begin
            best_way_reg   <= walk_reg;
            best_rank_reg  <= w_rank;
            best_reuse_reg <= w_reuse;
        end
        if ((state_reg == ST_WALK) && rd_phase_reg && last_way)
        begin
            res_way_reg  <= w_take ? walk_reg : best_way_reg;
            res_strm_reg <= strm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            walk_reg     <= '0;
            rd_phase_reg <= 1'b0;
            res_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= (state_reg == ST_WALK) && rd_phase_reg && last_way;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_JUDGE)
            begin
                walk_reg     <= '0;
                rd_phase_reg <= 1'b0;
            end
            else if (state_reg == ST_WALK)
            begin
                // read phase then compare phase for each way
                rd_phase_reg <= !rd_phase_reg;
                if (rd_phase_reg)
                begin
                    walk_reg <= walk_reg + 1'b1;
                end
            end
        end
    end

    assign result_valid = res_reg;
    assign victim_way   = sapr_pkg::WAY_IN_W'(res_way_reg);
    assign streaming    = res_strm_reg;
endmodule

// File: src/streaming_aware_pc_reuse_replacement_core.sv
// ---------------------------------------------------------------------------
// streaming_aware_pc_reuse_replacement_core
// pc-reuse llc replacement with per-set streaming detection
// ---------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; a two-entry queue lets
// the front take beats while the back works. After reset the back sweeps all
// per-set rows and the reuse table and takes no request meanwhile. An update
// is popped, reads its rows and writes them back. A victim request is popped,
// reads its rows, forms the products, judges streaming and walks the set, a
// read phase and a compare phase a way through the single reuse table read
// port, before its result is registered. Each victim result appears on
// victim_way/streaming for exactly one cycle with result_valid high; the
// receiver cannot stall it. Updates give no beat. Table sizes must be powers
// of two; the block itself does not enforce this.
module streaming_aware_pc_reuse_replacement_core #(
    parameter int NUM_SETS         = sapr_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS         = sapr_pkg::NUM_WAYS_DEF,
    parameter int PC_TABLE_ENTRIES = sapr_pkg::PC_TABLE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               action,
    input  logic [sapr_pkg::SET_IN_W-1:0]      set_index,
    input  logic [sapr_pkg::WAY_IN_W-1:0]      way_index,
    input  logic [sapr_pkg::PC_W-1:0]          pc,
    input  logic                               hit,
    output logic                               result_valid,
    output logic [sapr_pkg::WAY_IN_W-1:0]      victim_way,
    output logic                               streaming,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sapr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sapr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    sapr_pkg::req_t req_in, req_q;
    logic           req_valid, req_pop, clearing;
    logic [15:0]    access_window_reg;
    logic [7:0]     thresh_num_reg, thresh_den_reg;

    assign req_in = '{action: action, set_index: set_index, way_index: way_index,
                      pc: pc, hit: hit};
    assign cfg_ready = 1'b1;

    // config registers, writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_window_reg <= 16'd128;
            thresh_num_reg    <= 8'd4;
            thresh_den_reg    <= 8'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sapr_pkg::CFG_ACCESS_WINDOW: access_window_reg <= cfg_data;
                sapr_pkg::CFG_THRESH_NUM:    thresh_num_reg    <= cfg_data[7:0];
                sapr_pkg::CFG_THRESH_DEN:    thresh_den_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    sapr_front #(.QUEUE_DEPTH(sapr_pkg::QUEUE_DEPTH_DEF)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_in    (req_in),
        .req_valid (req_valid),
        .req_out   (req_q),
        .req_pop   (req_pop)
    );

    sapr_back #(
        .NUM_SETS         (NUM_SETS),
        .NUM_WAYS         (NUM_WAYS),
        .PC_TABLE_ENTRIES (PC_TABLE_ENTRIES)
    ) u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .req_valid             (req_valid),
        .req                   (req_q),
        .req_pop               (req_pop),
        .access_window         (access_window_reg),
        .threshold_numerator   (thresh_num_reg),
        .threshold_denominator (thresh_den_reg),
        .clearing              (clearing),
        .result_valid          (result_valid),
        .victim_way            (victim_way),
        .streaming             (streaming)
    );

`ifndef SYNTHESIS
    // no request leaves the queue during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !req_pop)
        else $error("request popped during clear");
    // results never come in back-to-back cycles
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |=> !result_valid)
        else $error("back-to-back results");
    // a full queue stays full unless the back pops
    assert property (@(posedge clk) disable iff (!rst_n) (busy && !req_pop) |=> busy)
        else $error("queue drained without pop");
`endif
endmodule

// File: tb/tb_streaming_aware_pc_reuse_replacement_core.sv
// ---------------------------------------------------------------------------
// tb_streaming_aware_pc_reuse_replacement_core
// self-checking bench for the pc-reuse llc replacement core
// ---------------------------------------------------------------------------
// A shadow copy of ranks, pc slots, reuse counters and per-set counters
// predicts each victim beat. Stimulus runs directed cases and then random
// fill/hit traffic on a small pool of sets and pc slots. The thresholds are
// swept between phases.
module tb_streaming_aware_pc_reuse_replacement_core;

    localparam int SETS      = sapr_pkg::NUM_SETS_DEF;
    localparam int WAYS      = sapr_pkg::NUM_WAYS_DEF;
    localparam int PC_SLOTS  = sapr_pkg::PC_TABLE_ENTRIES_DEF;
    // drain margin sized from the victim walk over every way
    localparam int DRAIN_CYCLES = 2 * WAYS + 30;
    // covers the clearing sweep after reset with a wide margin
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [sapr_pkg::WAY_IN_W-1:0] victim_way;
        logic                          streaming;
    } victim_beat_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              action = sapr_pkg::ACT_VICTIM;
    logic [sapr_pkg::SET_IN_W-1:0]     set_index = '0;
    logic [sapr_pkg::WAY_IN_W-1:0]     way_index = '0;
    logic [sapr_pkg::PC_W-1:0]         pc = '0;
    logic                              hit = 1'b0;
    logic                              result_valid;
    logic [sapr_pkg::WAY_IN_W-1:0]     victim_way;
    logic                              streaming;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [sapr_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [sapr_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    // shadow state of the replacement policy
    logic [3:0]                        rank_sh [SETS][WAYS];
    logic [11:0]                       slot_sh [SETS][WAYS];
    logic [sapr_pkg::REUSE_W-1:0]      reuse_sh [PC_SLOTS];
    logic [sapr_pkg::COUNT_W-1:0]      access_sh [SETS];
    logic [sapr_pkg::COUNT_W-1:0]      miss_sh [SETS];
    logic [15:0]                       window_sh;
    logic [7:0]                        num_sh;
    logic [7:0]                        den_sh;

    victim_beat_t                      victim_exp_q[$];
    int                                mismatch_count = 0;
    bit                                quiet = 1'b0;
    int                                idle_cycles = 0;
    logic [sapr_pkg::WAY_IN_W-1:0]     last_victim;

    // traffic pools: a few sets and pc slots so reuse and streaming build up
    logic [sapr_pkg::SET_IN_W-1:0]     set_pool [8];
    logic [11:0]                       slot_pool [24];

    always #5 clk = ~clk;

    streaming_aware_pc_reuse_replacement_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .set_index(set_index), .way_index(way_index),
        .pc(pc), .hit(hit), .result_valid(result_valid),
        .victim_way(victim_way), .streaming(streaming),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic void reset_shadow();
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                rank_sh[s][w] = w[3:0];
                slot_sh[s][w] = '0;
            end
            access_sh[s] = '0;
            miss_sh[s] = '0;
        end
        for (int p = 0; p < PC_SLOTS; p++)
            reuse_sh[p] = '0;
        window_sh = 16'd128;
        num_sh = 8'd4;
        den_sh = 8'd5;
    endfunction

    // counts the access and picks the way to evict
    function automatic victim_beat_t choose_victim(logic [sapr_pkg::SET_IN_W-1:0] s);
        victim_beat_t b;
        logic [63:0]  acc;
        logic [63:0]  mis;
        int           best_rank;
        int           best_reuse;
        int           c;
        int           r;
        if (access_sh[s] != sapr_pkg::COUNT_MAX)
            access_sh[s] = access_sh[s] + 1'b1;
        acc = {32'd0, access_sh[s]};
        mis = {32'd0, miss_sh[s]};
        b.streaming = (acc > {48'd0, window_sh}) &&
                      (mis * {56'd0, den_sh} > acc * {56'd0, num_sh});
        b.victim_way = '0;
        best_rank = 0;
        best_reuse = 8;
        for (int w = 0; w < WAYS; w++)
        begin
            r = int'(rank_sh[s][w]);
            c = int'(reuse_sh[slot_sh[s][w]]);
            if (b.streaming)
            begin
                if (r >= best_rank)
                begin
                    best_rank = r;
                    b.victim_way = w[3:0];
                end
            end
            else if (c < best_reuse || (c == best_reuse && r >= best_rank))
            begin
                best_reuse = c;
                best_rank = r;
                b.victim_way = w[3:0];
            end
        end
        return b;
    endfunction

    // trains the reuse counter and promotes the way to mru
    function automatic void train_line(logic [sapr_pkg::SET_IN_W-1:0] s,
                                       logic [sapr_pkg::WAY_IN_W-1:0] w,
                                       logic [sapr_pkg::PC_W-1:0] p, logic h);
        logic [11:0] sl;
        logic [3:0]  old_rank;
        sl = p[11:0];
        old_rank = rank_sh[s][w];
        if (!h && miss_sh[s] != sapr_pkg::COUNT_MAX)
            miss_sh[s] = miss_sh[s] + 1'b1;
        slot_sh[s][w] = sl;
        if (h && reuse_sh[sl] != sapr_pkg::REUSE_MAX)
            reuse_sh[sl] = reuse_sh[sl] + 1'b1;
        else if (!h && reuse_sh[sl] != '0)
            reuse_sh[sl] = reuse_sh[sl] - 1'b1;
        for (int i = 0; i < WAYS; i++)
            if (i != int'(w) && rank_sh[s][i] < old_rank)
                rank_sh[s][i] = rank_sh[s][i] + 1'b1;
        rank_sh[s][w] = '0;
    endfunction

    // sends one beat; called right after a rising edge, returns once busy reads
    // low right after an edge, or after a random sender gap that follows
    task automatic send_item(logic a, logic [sapr_pkg::SET_IN_W-1:0] s,
                             logic [sapr_pkg::WAY_IN_W-1:0] w,
                             logic [sapr_pkg::PC_W-1:0] p, logic h);
        victim_beat_t b;
        start <= 1'b1;
        action <= a;
        set_index <= s;
        way_index <= w;
        pc <= p;
        hit <= h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (a == sapr_pkg::ACT_VICTIM)
        begin
            b = choose_victim(s);
            last_victim = b.victim_way;
            victim_exp_q.push_back(b);
        end
        else
            train_line(s, w, p, h);
        // random sender gap, none in the final stretch
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // drains everything outstanding so that the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (victim_exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [sapr_pkg::CFG_IDX_W-1:0] idx,
                             logic [sapr_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == sapr_pkg::CFG_ACCESS_WINDOW)
            window_sh = val;
        else if (idx == sapr_pkg::CFG_THRESH_NUM)
            num_sh = val[7:0];
        else if (idx == sapr_pkg::CFG_THRESH_DEN)
            den_sh = val[7:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(logic [15:0] win, logic [7:0] nu, logic [7:0] de);
        wait_idle();
        write_reg(sapr_pkg::CFG_ACCESS_WINDOW, win);
        write_reg(sapr_pkg::CFG_THRESH_NUM, {8'd0, nu});
        write_reg(sapr_pkg::CFG_THRESH_DEN, {8'd0, de});
    endtask

    function automatic logic [sapr_pkg::PC_W-1:0] pool_pc();
        return {$urandom, 20'($urandom), slot_pool[$urandom_range(0, 23)]};
    endfunction

    // fresh sets, all pc extremes, every way at the edges
    task automatic test_directed_basic();
        send_item(sapr_pkg::ACT_VICTIM, 11'd0, 4'd0, '0, 1'b0);
        send_item(sapr_pkg::ACT_UPDATE, 11'd0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_item(sapr_pkg::ACT_UPDATE, 11'd0, 4'd0, 64'h0, 1'b0);
        send_item(sapr_pkg::ACT_VICTIM, 11'd0, 4'd7, 64'h0, 1'b1);
        send_item(sapr_pkg::ACT_UPDATE, 11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_item(sapr_pkg::ACT_VICTIM, 11'd2047, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // pc aliasing: same low bits, different upper bits share a counter
        send_item(sapr_pkg::ACT_UPDATE, 11'd5, 4'd3, 64'hAAAA_5555_0000_0123, 1'b1);
        send_item(sapr_pkg::ACT_UPDATE, 11'd5, 4'd4, 64'h5555_AAAA_FFFF_F123, 1'b1);
        send_item(sapr_pkg::ACT_VICTIM, 11'd5, 4'd0, 64'h0, 1'b0);
        // counter saturation at the top and bottom of the reuse score
        repeat (9) send_item(sapr_pkg::ACT_UPDATE, 11'd6, 4'd9, 64'h777, 1'b1);
        send_item(sapr_pkg::ACT_VICTIM, 11'd6, 4'd0, 64'h0, 1'b0);
        repeat (9) send_item(sapr_pkg::ACT_UPDATE, 11'd6, 4'd9, 64'h777, 1'b0);
        send_item(sapr_pkg::ACT_VICTIM, 11'd6, 4'd0, 64'h0, 1'b0);
    endtask

    // zero numerator: past the window any miss means streaming
    task automatic test_zero_numerator();
        set_thresholds(16'd0, 8'd0, 8'd255);
        send_item(sapr_pkg::ACT_UPDATE, 11'd9, 4'd2, 64'h10, 1'b0);
        send_item(sapr_pkg::ACT_VICTIM, 11'd9, 4'd0, 64'h0, 1'b0);
        send_item(sapr_pkg::ACT_VICTIM, 11'd10, 4'd0, 64'h0, 1'b0);
    endtask

    // zero denominator: never streaming however many misses
    task automatic test_zero_denominator();
        set_thresholds(16'd0, 8'd0, 8'd0);
        send_item(sapr_pkg::ACT_UPDATE, 11'd9, 4'd2, 64'h10, 1'b0);
        send_item(sapr_pkg::ACT_VICTIM, 11'd9, 4'd0, 64'h0, 1'b0);
    endtask

    // fill/hit traffic: victims each followed by a fill of that way, hit and miss updates and noise
    task automatic test_random_traffic(int n);
        logic [sapr_pkg::SET_IN_W-1:0] s;
        for (int i = 0; i < n; i++)
        begin
            s = set_pool[$urandom_range(0, 7)];
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    send_item(sapr_pkg::ACT_VICTIM, s, 4'($urandom), pool_pc(),
                              1'($urandom));
                    send_item(sapr_pkg::ACT_UPDATE, s, last_victim, pool_pc(), 1'b0);
                    i++;
                end
                4, 5, 6: send_item(sapr_pkg::ACT_UPDATE, s, 4'($urandom), pool_pc(), 1'b1);
                7: send_item(sapr_pkg::ACT_UPDATE, s, 4'($urandom), pool_pc(), 1'b0);
                // noise: anywhere in the set space, any pc
                default: send_item(1'($urandom), 11'($urandom), 4'($urandom),
                                   {$urandom, $urandom}, 1'($urandom));
            endcase
        end
    endtask

    // result check: each beat against the oldest expectation
    always @(posedge clk)
    begin
        victim_beat_t e;
        if (rst_n && result_valid)
        begin
            if (victim_exp_q.size() == 0)
            begin
                $error("victim beat with nothing expected: way %0d streaming %0d",
                       victim_way, streaming);
                mismatch_count++;
            end
            else
            begin
                e = victim_exp_q.pop_front();
                if (victim_way !== e.victim_way)
                begin
                    $error("victim_way expected %0d actual %0d", e.victim_way, victim_way);
                    mismatch_count++;
                end
                if (streaming !== e.streaming)
                begin
                    $error("streaming expected %0d actual %0d", e.streaming, streaming);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        reset_shadow();
        set_pool[0] = 11'd0;
        set_pool[1] = 11'd2047;
        for (int i = 2; i < 8; i++)
            set_pool[i] = 11'($urandom);
        for (int i = 0; i < 24; i++)
            slot_pool[i] = 12'($urandom);
        slot_pool[0] = 12'h000;
        slot_pool[1] = 12'hFFF;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basic();
        test_zero_numerator();
        test_zero_denominator();

        // reset defaults, written back explicitly
        set_thresholds(16'd128, 8'd4, 8'd5);
        test_random_traffic(250);
        set_thresholds(16'd4, 8'd1, 8'd2);
        test_random_traffic(200);
        set_thresholds(16'd65535, 8'd255, 8'd255);
        test_random_traffic(120);
        set_thresholds(16'($urandom_range(0, 40)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(1, 255)));
        test_random_traffic(150);
        set_thresholds(16'd2, 8'd1, 8'd1);
        quiet = 1'b1;
        test_random_traffic(180);

        wait_idle();
        if (mismatch_count == 0 && victim_exp_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
